>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the maze backtracker step block.
// Empty bodies when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(name, ck, rn, ante, cons, msg)
`define ASSERT_NEXT(name, ck, rn, ante, cons, msg)
`endif
`endif

>>> hdl/mbs_pkg.sv
// Package for the maze backtracker step block: field widths, codes,
// controller/datapath command and status types, and small decode functions.
`timescale 1ns / 1ps

package mbs_pkg;

    localparam int GRID_SIDE_DEF = 32;
    localparam int START_W       = 10;
    localparam int PICK_W        = 8;
    localparam int CELL_FIELD_W  = 10;
    localparam int TOTAL_W       = 11;

    localparam logic [START_W-1:0] START_CELL_RST = 10'd40;

    // input op codes
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_CARVE   = 1'b1;

    // wall bits of one cell
    localparam logic [3:0] WALL_TOP    = 4'b0001;
    localparam logic [3:0] WALL_RIGHT  = 4'b0010;
    localparam logic [3:0] WALL_BOTTOM = 4'b0100;
    localparam logic [3:0] WALL_LEFT   = 4'b1000;
    localparam logic [3:0] WALLS_ALL   = 4'b1111;

    // neighbor directions in candidate order
    typedef enum logic [1:0] {
        DIR_COL_DEC = 2'd0,
        DIR_ROW_INC = 2'd1,
        DIR_COL_INC = 2'd2,
        DIR_ROW_DEC = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        CW_NONE,
        CW_CLEAR,
        CW_SEED,
        CW_HERE,
        CW_THERE
    } cell_wr_t;

    typedef enum logic [2:0] {
        RS_NONE,
        RS_HERE,
        RS_COL_DEC,
        RS_ROW_INC,
        RS_COL_INC,
        RS_ROW_DEC
    } rd_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R_INIT,
        ST_R_CLEAR,
        ST_R_SEED,
        ST_RD_HERE,
        ST_RD_N0,
        ST_RD_N1,
        ST_RD_N2,
        ST_RD_N3,
        ST_RD_LAST,
        ST_DECIDE,
        ST_CARVE_HERE,
        ST_CARVE_THERE,
        ST_POP_RD,
        ST_POP_LD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     take_item;
        logic     restart_init;
        cell_wr_t cell_wr;
        rd_sel_t  rd_sel;
        rd_sel_t  cap_sel;
        logic     decide;
        logic     pop_rd;
        logic     pop_ld;
        logic     load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic div_done;
        logic done_all;
        logic has_cand;
        logic stack_nonempty;
    } dp_status_t;

    function automatic logic [3:0] here_mask(input dir_t dir);
        logic [3:0] m;
        unique case (dir)
            DIR_COL_DEC: m = WALL_LEFT;
            DIR_ROW_INC: m = WALL_BOTTOM;
            DIR_COL_INC: m = WALL_RIGHT;
            DIR_ROW_DEC: m = WALL_TOP;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] there_mask(input dir_t dir);
        logic [3:0] m;
        unique case (dir)
            DIR_COL_DEC: m = WALL_RIGHT;
            DIR_ROW_INC: m = WALL_TOP;
            DIR_COL_INC: m = WALL_LEFT;
            DIR_ROW_DEC: m = WALL_BOTTOM;
        endcase
        return m;
    endfunction

    // byte mod 3: base-4 digits are each congruent to themselves mod 3
    function automatic logic [1:0] mod3_byte(input logic [PICK_W-1:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd6)
        begin
            t = t - 3'd6;
        end
        else if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    // random value modulo candidate count (1 to 4)
    function automatic logic [1:0] pick_slot(input logic [PICK_W-1:0] r,
                                             input logic [2:0] cnt);
        logic [1:0] p;
        case (cnt)
            3'd2:    p = {1'b0, r[0]};
            3'd3:    p = mod3_byte(r);
            3'd4:    p = r[1:0];
            default: p = 2'd0;
        endcase
        return p;
    endfunction

    // direction of the slot-th set bit of the candidate mask
    function automatic dir_t nth_set(input logic [3:0] mask, input logic [1:0] slot);
        logic [1:0] seen;
        dir_t       pick;
        seen = 2'd0;
        pick = DIR_COL_DEC;
        for (int i = 0; i < 4; i++)
        begin
            if (mask[i])
            begin
                if (seen == slot)
                begin
                    pick = dir_t'(2'(i));
                end
                seen = seen + 2'd1;
            end
        end
        return pick;
    endfunction

endpackage

>>> hdl/mbs_if.sv
// Handshake channel interfaces of the maze backtracker step block:
// step input, step result and start-cell configuration. Uses mbs_pkg.
`timescale 1ns / 1ps

interface mbs_in_if import mbs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [PICK_W-1:0] random_pick;

    modport source (output valid, output op, output random_pick, input ready);
    modport sink   (input valid, input op, input random_pick, output ready);
endinterface

interface mbs_out_if import mbs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    carved;
    logic [CELL_FIELD_W-1:0] from_cell;
    logic [CELL_FIELD_W-1:0] to_cell;
    logic                    backtracked;
    logic [CELL_FIELD_W-1:0] head_cell;
    logic [TOTAL_W-1:0]      visited_total;
    logic                    done_res;

    modport source (output valid, output carved, output from_cell, output to_cell,
                    output backtracked, output head_cell, output visited_total,
                    output done_res, input ready);
    modport sink   (input valid, input carved, input from_cell, input to_cell,
                    input backtracked, input head_cell, input visited_total,
                    input done_res, output ready);
endinterface

interface mbs_cfg_if import mbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [START_W-1:0] start_cell;

    modport source (output valid, output start_cell, input ready);
    modport sink   (input valid, input start_cell, output ready);
endinterface

>>> hdl/maze_backtracker_step_top.sv
// Step: after the input transfer the block reads the current cell and its neighbors on the single
// cell RAM read port, decides, writes two cells or does a pop read/load, then loads the result.
// A new step is taken only after that load, which waits while the previous result is unsent.
// Restart: init, a clearing sweep of every cell, seed and result load, input not ready; reset runs it too.
// A step after every cell is visited goes straight to the result load. Config writes are always taken.
// Uses mbs_pkg, mbs_if, mbs_ctrl, mbs_dp, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module maze_backtracker_step_top import mbs_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mbs_cfg_if.sink   cfg,
    mbs_in_if.sink    step_in,
    mbs_out_if.source step_out
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;

    assign cfg.ready     = 1'b1;
    assign step_in.ready = in_ready;
    assign step_out.valid = out_valid;

    mbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step_in.valid),
        .in_op     (step_in.op),
        .out_ready (step_out.ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mbs_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg.valid && cfg.ready),
        .cfg_start     (cfg.start_cell),
        .random_pick   (step_in.random_pick),
        .cmd           (cmd),
        .status        (status),
        .carved        (step_out.carved),
        .from_cell     (step_out.from_cell),
        .to_cell       (step_out.to_cell),
        .backtracked   (step_out.backtracked),
        .head_cell     (step_out.head_cell),
        .visited_total (step_out.visited_total),
        .done_res      (step_out.done_res)
    );

    `ASSERT_IMPLY(a_no_overrun, clk, rst_n, cmd.load_out, !out_valid || step_out.ready, "result register overwritten before transfer")
    `ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, cmd.pop_rd, status.stack_nonempty, "pop from an empty path stack")
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, cmd.take_item, !in_ready, "input still ready after an item transfer")
    `ASSERT_IMPLY(a_carve_or_back, clk, rst_n, out_valid, !(step_out.carved && step_out.backtracked), "result both carved and backtracked")

endmodule

>>> hdl/mbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mbs_ctrl.sv
// Controller state machine of the maze backtracker step block: sequences
// restart sweeps, neighbor reads, carve or pop, and the result transfer. Uses mbs_pkg.
`timescale 1ns / 1ps

module mbs_ctrl import mbs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_op,
    input  logic       out_ready,
    input  dp_status_t status,
    output logic       in_ready,
    output logic       out_valid,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   report_reg, report_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_R_INIT;
            report_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            report_reg    <= report_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_RESTART)
                    begin
                        state_next  = ST_R_INIT;
                        report_next = 1'b1;
                    end
                    else if (status.done_all)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_RD_HERE;
                    end
                end
            end
            ST_R_INIT:  state_next = ST_R_CLEAR;
            ST_R_CLEAR:
            begin
                if (status.sweep_done && status.div_done)
                begin
                    state_next = ST_R_SEED;
                end
            end
            ST_R_SEED:
            begin
                state_next  = report_reg ? ST_FINISH : ST_IDLE;
                report_next = 1'b0;
            end
            ST_RD_HERE: state_next = ST_RD_N0;
            ST_RD_N0:   state_next = ST_RD_N1;
            ST_RD_N1:   state_next = ST_RD_N2;
            ST_RD_N2:   state_next = ST_RD_N3;
            ST_RD_N3:   state_next = ST_RD_LAST;
            ST_RD_LAST: state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (status.has_cand)
                begin
                    state_next = ST_CARVE_HERE;
                end
                else if (status.stack_nonempty)
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CARVE_HERE:  state_next = ST_CARVE_THERE;
            ST_CARVE_THERE: state_next = ST_FINISH;
            ST_POP_RD:      state_next = ST_POP_LD;
            ST_POP_LD:      state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.cell_wr  = CW_NONE;
        cmd.rd_sel   = RS_NONE;
        cmd.cap_sel  = RS_NONE;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_item = in_valid;
            end
            ST_R_INIT:      cmd.restart_init = 1'b1;
            ST_R_CLEAR:     cmd.cell_wr = CW_CLEAR;
            ST_R_SEED:      cmd.cell_wr = CW_SEED;
            ST_RD_HERE:     cmd.rd_sel = RS_HERE;
            ST_RD_N0:
            begin
                cmd.rd_sel  = RS_COL_DEC;
                cmd.cap_sel = RS_HERE;
            end
            ST_RD_N1:
            begin
                cmd.rd_sel  = RS_ROW_INC;
                cmd.cap_sel = RS_COL_DEC;
            end
            ST_RD_N2:
            begin
                cmd.rd_sel  = RS_COL_INC;
                cmd.cap_sel = RS_ROW_INC;
            end
            ST_RD_N3:
            begin
                cmd.rd_sel  = RS_ROW_DEC;
                cmd.cap_sel = RS_COL_INC;
            end
            ST_RD_LAST:     cmd.cap_sel = RS_ROW_DEC;
            ST_DECIDE:      cmd.decide = 1'b1;
            ST_CARVE_HERE:  cmd.cell_wr = CW_HERE;
            ST_CARVE_THERE: cmd.cell_wr = CW_THERE;
            ST_POP_RD:      cmd.pop_rd = 1'b1;
            ST_POP_LD:      cmd.pop_ld = 1'b1;
            ST_FINISH:      cmd.load_out = out_free;
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.load_out;
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hdl/mbs_dp.sv
// Datapath of the maze backtracker step block: cell and stack RAMs, current
// cell, counters, neighbor capture, pick logic and result register. Uses mbs_pkg, mbs_ram.
`timescale 1ns / 1ps

module mbs_dp import mbs_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [START_W-1:0]      cfg_start,
    input  logic [PICK_W-1:0]       random_pick,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              status,
    output logic                    carved,
    output logic [CELL_FIELD_W-1:0] from_cell,
    output logic [CELL_FIELD_W-1:0] to_cell,
    output logic                    backtracked,
    output logic [CELL_FIELD_W-1:0] head_cell,
    output logic [TOTAL_W-1:0]      visited_total,
    output logic                    done_res
);

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int ROW_W      = $clog2(GRID_SIDE);
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = CELL_W + 1;
    localparam int COORD_W    = 2 * ROW_W;
    localparam int ENTRY_W    = 5;

    localparam logic [CELL_W-1:0]  SIDE_IDX  = CELL_W'(GRID_SIDE);
    localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(GRID_SIDE - 1);
    localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(CELL_COUNT);
    localparam logic [START_W-1:0] SIDE_SEED = START_W'(GRID_SIDE);

    // configuration and restart
    logic [START_W-1:0] start_cell_reg;
    logic [START_W-1:0] seed_reg;
    logic [START_W-1:0] seed_next;
    logic [START_W-1:0] div_rem_reg;
    logic [ROW_W-1:0]   div_col_reg;
    logic [CNT_W-1:0]   sweep_reg;

    // walk state
    logic [ROW_W-1:0]   cur_col_reg;
    logic [ROW_W-1:0]   cur_row_reg;
    logic [CELL_W-1:0]  cur_idx_reg;
    logic [CNT_W-1:0]   depth_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PICK_W-1:0]  rand_reg;
    logic [3:0]         here_walls_reg;
    logic [3:0]         nb_walls_reg [4];
    logic [3:0]         nb_vis_reg;
    dir_t               dir_reg;

    // step result
    logic               carved_reg;
    logic               back_reg;
    logic [CELL_W-1:0]  from_reg;
    logic [CELL_W-1:0]  to_reg;

    // output register
    logic                    out_carved_reg;
    logic [CELL_FIELD_W-1:0] out_from_reg;
    logic [CELL_FIELD_W-1:0] out_to_reg;
    logic                    out_back_reg;
    logic [CELL_FIELD_W-1:0] out_head_reg;
    logic [TOTAL_W-1:0]      out_total_reg;
    logic                    out_done_reg;

    // combinational
    logic [3:0]         in_grid;
    logic [3:0]         cand;
    logic [2:0]         cand_cnt;
    logic [ROW_W-1:0]   nb_col [4];
    logic [ROW_W-1:0]   nb_row [4];
    logic [CELL_W-1:0]  nb_idx [4];
    logic [CELL_W-1:0]  nx_idx;
    logic [ROW_W-1:0]   nx_col;
    logic [ROW_W-1:0]   nx_row;
    logic               sweep_done;
    logic               div_done;
    logic               stack_room;
    logic [CNT_W-1:0]   depth_m1;

    logic               cell_we;
    logic [CELL_W-1:0]  cell_waddr;
    logic [ENTRY_W-1:0] cell_wdata;
    logic [CELL_W-1:0]  cell_raddr;
    logic [ENTRY_W-1:0] cell_rdata;

    logic               stack_we;
    logic [CELL_W-1:0]  stack_waddr;
    logic [COORD_W-1:0] stack_wdata;
    logic [CELL_W-1:0]  stack_raddr;
    logic [COORD_W-1:0] stack_rdata;

    // entry layout: {walls, visited}
    mbs_ram #(.WIDTH(ENTRY_W), .DEPTH(CELL_COUNT)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // entry layout: {column, row}
    mbs_ram #(.WIDTH(COORD_W), .DEPTH(CELL_COUNT)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    assign sweep_done = (sweep_reg == FULL_CNT);
    assign div_done   = (div_rem_reg < SIDE_SEED);
    assign stack_room = (depth_reg != FULL_CNT);
    assign depth_m1   = depth_reg - CNT_W'(1);
    assign seed_next  = (32'(start_cell_reg) < 32'(CELL_COUNT)) ? start_cell_reg : '0;

    // neighbor geometry of the current cell
    always_comb
    begin
        in_grid[DIR_COL_DEC] = (cur_col_reg != '0);
        in_grid[DIR_ROW_INC] = (cur_row_reg != LAST_ROW);
        in_grid[DIR_COL_INC] = (cur_col_reg != LAST_ROW);
        in_grid[DIR_ROW_DEC] = (cur_row_reg != '0);

        nb_col[DIR_COL_DEC] = cur_col_reg - ROW_W'(1);
        nb_row[DIR_COL_DEC] = cur_row_reg;
        nb_idx[DIR_COL_DEC] = cur_idx_reg - SIDE_IDX;
        nb_col[DIR_ROW_INC] = cur_col_reg;
        nb_row[DIR_ROW_INC] = cur_row_reg + ROW_W'(1);
        nb_idx[DIR_ROW_INC] = cur_idx_reg + CELL_W'(1);
        nb_col[DIR_COL_INC] = cur_col_reg + ROW_W'(1);
        nb_row[DIR_COL_INC] = cur_row_reg;
        nb_idx[DIR_COL_INC] = cur_idx_reg + SIDE_IDX;
        nb_col[DIR_ROW_DEC] = cur_col_reg;
        nb_row[DIR_ROW_DEC] = cur_row_reg - ROW_W'(1);
        nb_idx[DIR_ROW_DEC] = cur_idx_reg - CELL_W'(1);
    end

    assign cand     = in_grid & ~nb_vis_reg;
    assign cand_cnt = 3'($countones(cand));
    assign nx_idx   = nb_idx[dir_reg];
    assign nx_col   = nb_col[dir_reg];
    assign nx_row   = nb_row[dir_reg];

    // cell RAM read address; an off-grid neighbor reads the current cell
    always_comb
    begin
        unique case (cmd.rd_sel)
            RS_NONE:    cell_raddr = cur_idx_reg;
            RS_HERE:    cell_raddr = cur_idx_reg;
            RS_COL_DEC: cell_raddr = in_grid[DIR_COL_DEC] ? nb_idx[DIR_COL_DEC] : cur_idx_reg;
            RS_ROW_INC: cell_raddr = in_grid[DIR_ROW_INC] ? nb_idx[DIR_ROW_INC] : cur_idx_reg;
            RS_COL_INC: cell_raddr = in_grid[DIR_COL_INC] ? nb_idx[DIR_COL_INC] : cur_idx_reg;
            RS_ROW_DEC: cell_raddr = in_grid[DIR_ROW_DEC] ? nb_idx[DIR_ROW_DEC] : cur_idx_reg;
            default:    cell_raddr = cur_idx_reg;
        endcase
    end

    // cell RAM write port
    always_comb
    begin
        unique case (cmd.cell_wr)
            CW_CLEAR:
            begin
                cell_we    = !sweep_done;
                cell_waddr = sweep_reg[CELL_W-1:0];
                cell_wdata = {WALLS_ALL, 1'b0};
            end
            CW_SEED:
            begin
                cell_we    = 1'b1;
                cell_waddr = CELL_W'(seed_reg);
                cell_wdata = {WALLS_ALL, 1'b1};
            end
            CW_HERE:
            begin
                cell_we    = 1'b1;
                cell_waddr = cur_idx_reg;
                cell_wdata = {here_walls_reg & ~here_mask(dir_reg), 1'b1};
            end
            CW_THERE:
            begin
                cell_we    = 1'b1;
                cell_waddr = nx_idx;
                cell_wdata = {nb_walls_reg[dir_reg] & ~there_mask(dir_reg), 1'b1};
            end
            default:
            begin
                cell_we    = 1'b0;
                cell_waddr = cur_idx_reg;
                cell_wdata = '0;
            end
        endcase
    end

    // stack RAM: seed the bottom entry or push the carved cell
    always_comb
    begin
        if (cmd.cell_wr == CW_SEED)
        begin
            stack_we    = 1'b1;
            stack_waddr = '0;
            stack_wdata = {div_col_reg, ROW_W'(div_rem_reg)};
        end
        else
        begin
            stack_we    = (cmd.cell_wr == CW_HERE) && stack_room;
            stack_waddr = depth_reg[CELL_W-1:0];
            stack_wdata = {nx_col, nx_row};
        end
    end

    assign stack_raddr = depth_m1[CELL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_cell_reg <= START_CELL_RST;
        end
        else if (cfg_we)
        begin
            start_cell_reg <= cfg_start;
        end
    end

    // restart sweep and start cell split into column and row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= '0;
            div_rem_reg <= '0;
            div_col_reg <= '0;
            sweep_reg   <= '0;
        end
        else if (cmd.restart_init)
        begin
            seed_reg    <= seed_next;
            div_rem_reg <= seed_next;
            div_col_reg <= '0;
            sweep_reg   <= '0;
        end
        else if (cmd.cell_wr == CW_CLEAR)
        begin
            if (!sweep_done)
            begin
                sweep_reg <= sweep_reg + CNT_W'(1);
            end
            if (!div_done)
            begin
                div_rem_reg <= div_rem_reg - SIDE_SEED;
                div_col_reg <= div_col_reg + ROW_W'(1);
            end
        end
    end

    // current cell, stack depth and visited count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            cur_idx_reg <= '0;
            depth_reg   <= '0;
            count_reg   <= '0;
        end
        else if (cmd.cell_wr == CW_SEED)
        begin
            cur_col_reg <= div_col_reg;
            cur_row_reg <= ROW_W'(div_rem_reg);
            cur_idx_reg <= CELL_W'(seed_reg);
            depth_reg   <= CNT_W'(1);
            count_reg   <= CNT_W'(1);
        end
        else if (cmd.cell_wr == CW_HERE)
        begin
            if (stack_room)
            begin
                depth_reg <= depth_reg + CNT_W'(1);
            end
        end
        else if (cmd.cell_wr == CW_THERE)
        begin
            cur_col_reg <= nx_col;
            cur_row_reg <= nx_row;
            cur_idx_reg <= nx_idx;
            count_reg   <= count_reg + CNT_W'(1);
        end
        else if (cmd.pop_rd)
        begin
            depth_reg <= depth_m1;
        end
        else if (cmd.pop_ld)
        begin
            cur_col_reg <= stack_rdata[COORD_W-1:ROW_W];
            cur_row_reg <= stack_rdata[ROW_W-1:0];
            cur_idx_reg <= CELL_W'(stack_rdata[COORD_W-1:ROW_W]) * SIDE_IDX
                         + CELL_W'(stack_rdata[ROW_W-1:0]);
        end
    end

    // neighbor capture, pick and per-step result
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            rand_reg   <= random_pick;
            carved_reg <= 1'b0;
            back_reg   <= 1'b0;
            from_reg   <= '0;
            to_reg     <= '0;
        end
        unique case (cmd.cap_sel)
            RS_NONE:    ;
            RS_HERE:    here_walls_reg <= cell_rdata[ENTRY_W-1:1];
            RS_COL_DEC:
            begin
                nb_walls_reg[DIR_COL_DEC] <= cell_rdata[ENTRY_W-1:1];
                nb_vis_reg[DIR_COL_DEC]   <= cell_rdata[0];
            end
            RS_ROW_INC:
            begin
                nb_walls_reg[DIR_ROW_INC] <= cell_rdata[ENTRY_W-1:1];
                nb_vis_reg[DIR_ROW_INC]   <= cell_rdata[0];
            end
            RS_COL_INC:
            begin
                nb_walls_reg[DIR_COL_INC] <= cell_rdata[ENTRY_W-1:1];
                nb_vis_reg[DIR_COL_INC]   <= cell_rdata[0];
            end
            RS_ROW_DEC:
            begin
                nb_walls_reg[DIR_ROW_DEC] <= cell_rdata[ENTRY_W-1:1];
                nb_vis_reg[DIR_ROW_DEC]   <= cell_rdata[0];
            end
            default:    ;
        endcase
        if (cmd.decide)
        begin
            dir_reg <= nth_set(cand, pick_slot(rand_reg, cand_cnt));
        end
        if (cmd.cell_wr == CW_HERE)
        begin
            carved_reg <= 1'b1;
            from_reg   <= cur_idx_reg;
        end
        if (cmd.cell_wr == CW_THERE)
        begin
            to_reg <= nx_idx;
        end
        if (cmd.pop_ld)
        begin
            back_reg <= 1'b1;
        end
    end

    // result register, loaded once the previous result has left
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_carved_reg <= carved_reg;
            out_from_reg   <= CELL_FIELD_W'(from_reg);
            out_to_reg     <= CELL_FIELD_W'(to_reg);
            out_back_reg   <= back_reg;
            out_head_reg   <= CELL_FIELD_W'(cur_idx_reg);
            out_total_reg  <= TOTAL_W'(count_reg);
            out_done_reg   <= (count_reg == FULL_CNT);
        end
    end

    always_comb
    begin
        status.sweep_done     = sweep_done;
        status.div_done       = div_done;
        status.done_all       = (count_reg == FULL_CNT);
        status.has_cand       = |cand;
        status.stack_nonempty = (depth_reg != '0);
    end

    assign carved        = out_carved_reg;
    assign from_cell     = out_from_reg;
    assign to_cell       = out_to_reg;
    assign backtracked   = out_back_reg;
    assign head_cell     = out_head_reg;
    assign visited_total = out_total_reg;
    assign done_res      = out_done_reg;

endmodule

>>> tb/maze_backtracker_step_top_tb.sv
// Testbench for maze_backtracker_step_top: drives step and start-cell transfers,
// predicts every step result and checks the result channel field by field.
// Depends on mbs_pkg, the mbs_if channel interfaces and the block itself.
`timescale 1ns / 1ps

module maze_backtracker_step_top_tb import mbs_pkg::*; ();

    localparam int          SIDE        = GRID_SIDE_DEF;
    localparam int          CELLS       = SIDE * SIDE;
    localparam int          HOLD_CYCLES = 300;
    localparam int          QUIET_LIMIT = 6000;
    localparam int          TAIL_CYCLES = 40;
    localparam int          PRINT_CAP   = 25;

    typedef enum logic [2:0] {
        ACT_STEP,
        ACT_START_WR,
        ACT_SETTLE,
        ACT_HOLD_OUT,
        ACT_IDLE_MIX
    } act_t;

    typedef struct {
        act_t               act;
        logic               op;
        logic [PICK_W-1:0]  pick;
        logic [START_W-1:0] start;
        int                 in_pct;
        int                 out_pct;
    } plan_t;

    typedef struct packed {
        logic                    carved;
        logic [CELL_FIELD_W-1:0] from_cell;
        logic [CELL_FIELD_W-1:0] to_cell;
        logic                    backtracked;
        logic [CELL_FIELD_W-1:0] head_cell;
        logic [TOTAL_W-1:0]      visited_total;
        logic                    done_res;
    } move_t;

    logic clk = 1'b0;
    logic rst_n;

    mbs_cfg_if cfg_ch ();
    mbs_in_if  step_ch ();
    mbs_out_if res_ch ();

    maze_backtracker_step_top #(
        .GRID_SIDE (SIDE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .step_in  (step_ch),
        .step_out (res_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // maze state as the block should hold it
    bit                      visited [CELLS];
    logic [3:0]              walls [CELLS];
    logic [CELL_FIELD_W-1:0] trail [CELLS];
    int unsigned             trail_depth;
    int unsigned             head;
    int unsigned             seen_total;
    logic [START_W-1:0]      start_reg;

    plan_t step_plan [$];
    move_t expected_moves [$];

    logic in_fire  = 1'b0;
    logic cfg_fire = 1'b0;
    int   in_idle_pct  = 0;
    int   out_idle_pct = 0;
    int   hold_ticket  = 0;
    int   hold_seen    = 0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;
    int   mismatches   = 0;

    task automatic reseed_maze();
        int unsigned s;
        s = (32'(start_reg) < CELLS) ? 32'(start_reg) : 32'd0;
        for (int i = 0; i < CELLS; i++)
        begin
            visited[i] = 1'b0;
            walls[i]   = WALLS_ALL;
        end
        visited[s]  = 1'b1;
        trail[0]    = CELL_FIELD_W'(s);
        trail_depth = 1;
        head        = s;
        seen_total  = 1;
    endtask

    // carve toward an unvisited neighbor, or pop the trail when boxed in
    task automatic carve_or_backtrack(input logic op, input logic [PICK_W-1:0] pick);
        move_t       r;
        int unsigned col, row, n, slot, nx;
        int unsigned nb_cell [4];
        logic [3:0]  nb_here [4];
        logic [3:0]  nb_there [4];
        r = '0;
        n = 0;
        if (op == OP_RESTART)
        begin
            reseed_maze();
        end
        else if (seen_total < CELLS)
        begin
            col = head / SIDE;
            row = head % SIDE;
            if (col > 0 && !visited[head - SIDE])
            begin
                nb_cell[n] = head - SIDE;
                nb_here[n] = WALL_LEFT;
                nb_there[n] = WALL_RIGHT;
                n++;
            end
            if (row + 1 < SIDE && !visited[head + 1])
            begin
                nb_cell[n] = head + 1;
                nb_here[n] = WALL_BOTTOM;
                nb_there[n] = WALL_TOP;
                n++;
            end
            if (col + 1 < SIDE && !visited[head + SIDE])
            begin
                nb_cell[n] = head + SIDE;
                nb_here[n] = WALL_RIGHT;
                nb_there[n] = WALL_LEFT;
                n++;
            end
            if (row > 0 && !visited[head - 1])
            begin
                nb_cell[n] = head - 1;
                nb_here[n] = WALL_TOP;
                nb_there[n] = WALL_BOTTOM;
                n++;
            end
            if (n > 0)
            begin
                slot = 32'(pick) % n;
                nx = nb_cell[slot];
                visited[nx] = 1'b1;
                if (trail_depth < CELLS)
                begin
                    trail[trail_depth] = CELL_FIELD_W'(nx);
                    trail_depth++;
                end
                walls[head] = walls[head] & ~nb_here[slot];
                walls[nx]   = walls[nx] & ~nb_there[slot];
                r.carved    = 1'b1;
                r.from_cell = CELL_FIELD_W'(head);
                r.to_cell   = CELL_FIELD_W'(nx);
                head = nx;
                seen_total++;
            end
            else if (trail_depth > 0)
            begin
                trail_depth--;
                head = 32'(trail[trail_depth]);
                r.backtracked = 1'b1;
            end
        end
        r.head_cell     = CELL_FIELD_W'(head);
        r.visited_total = TOTAL_W'(seen_total);
        r.done_res      = (seen_total >= CELLS);
        expected_moves.insert(expected_moves.size(), r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    task automatic add_step(input logic op, input logic [PICK_W-1:0] pick);
        plan_t p;
        p = '{act: ACT_STEP, op: op, pick: pick, start: '0, in_pct: 0, out_pct: 0};
        step_plan.insert(step_plan.size(), p);
    endtask

    task automatic add_marker(input act_t act);
        plan_t p;
        p = '{act: act, op: OP_RESTART, pick: '0, start: '0, in_pct: 0, out_pct: 0};
        step_plan.insert(step_plan.size(), p);
    endtask

    // drain first so the write lands on an idle block, then restart to apply it
    task automatic add_start_wr(input logic [START_W-1:0] value);
        plan_t p;
        add_marker(ACT_SETTLE);
        p = '{act: ACT_START_WR, op: OP_RESTART, pick: '0, start: value, in_pct: 0, out_pct: 0};
        step_plan.insert(step_plan.size(), p);
        add_step(OP_RESTART, PICK_W'($urandom));
    endtask

    task automatic add_idle_mix(input int in_pct, input int out_pct);
        plan_t p;
        p = '{act: ACT_IDLE_MIX, op: OP_RESTART, pick: '0, start: '0,
              in_pct: in_pct, out_pct: out_pct};
        step_plan.insert(step_plan.size(), p);
    endtask

    task automatic add_random_run(input int count, input int restart_pct);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < restart_pct)
            begin
                add_step(OP_RESTART, PICK_W'($urandom));
            end
            else if (roll < restart_pct + 5)
            begin
                add_step(OP_CARVE, ($urandom_range(1) != 0) ? 8'hFF : 8'h00);
            end
            else
            begin
                add_step(OP_CARVE, PICK_W'($urandom));
            end
        end
    endtask

    // from cell 0, a pick whose low bit follows the column parity carves a column snake
    task automatic add_snake_run(input int count);
        logic [PICK_W-1:0] pick;
        for (int i = 0; i < count; i++)
        begin
            pick    = PICK_W'($urandom);
            pick[0] = 1'((i / SIDE) % 2);
            add_step(OP_CARVE, pick);
        end
    endtask

    // step and start-cell driver
    always @(negedge clk)
    begin : drive
        logic               nxt_step;
        logic               nxt_cfg;
        logic               nxt_op;
        logic [PICK_W-1:0]  nxt_pick;
        logic [START_W-1:0] nxt_start;
        nxt_step  = 1'b0;
        nxt_cfg   = 1'b0;
        nxt_op    = OP_RESTART;
        nxt_pick  = '0;
        nxt_start = '0;
        // hold an offered transfer until it is taken
        if (!(step_ch.valid && !in_fire) && !(cfg_ch.valid && !cfg_fire))
        begin
            if (rst_n && step_plan.size() != 0)
            begin
                case (step_plan[0].act)
                    ACT_STEP:
                    begin
                        if ($urandom_range(99) >= in_idle_pct)
                        begin
                            nxt_step = 1'b1;
                            nxt_op   = step_plan[0].op;
                            nxt_pick = step_plan[0].pick;
                        end
                    end
                    ACT_START_WR:
                    begin
                        nxt_cfg   = 1'b1;
                        nxt_start = step_plan[0].start;
                    end
                    ACT_SETTLE:
                    begin
                        if (expected_moves.size() == 0)
                        begin
                            void'(step_plan.pop_front());
                        end
                    end
                    ACT_HOLD_OUT:
                    begin
                        hold_ticket <= hold_ticket + 1;
                        void'(step_plan.pop_front());
                    end
                    ACT_IDLE_MIX:
                    begin
                        in_idle_pct  = step_plan[0].in_pct;
                        out_idle_pct <= step_plan[0].out_pct;
                        void'(step_plan.pop_front());
                    end
                    default:
                    begin
                        void'(step_plan.pop_front());
                    end
                endcase
            end
            step_ch.valid       <= nxt_step;
            step_ch.op          <= nxt_op;
            step_ch.random_pick <= nxt_pick;
            cfg_ch.valid        <= nxt_cfg;
            cfg_ch.start_cell   <= nxt_start;
        end
    end

    // result receiver: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (hold_seen != hold_ticket)
        begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // monitor: track transfers, predict, compare, watch for a stall
    always @(posedge clk)
    begin : watch
        move_t want;
        move_t got;
        logic  out_fire;
        in_fire  = rst_n && step_ch.valid && step_ch.ready;
        cfg_fire = rst_n && cfg_ch.valid && cfg_ch.ready;
        out_fire = rst_n && res_ch.valid && res_ch.ready;
        if (cfg_fire)
        begin
            start_reg = cfg_ch.start_cell;
            void'(step_plan.pop_front());
        end
        if (in_fire)
        begin
            carve_or_backtrack(step_ch.op, step_ch.random_pick);
            void'(step_plan.pop_front());
        end
        if (out_fire)
        begin
            got = '{carved: res_ch.carved, from_cell: res_ch.from_cell,
                    to_cell: res_ch.to_cell, backtracked: res_ch.backtracked,
                    head_cell: res_ch.head_cell, visited_total: res_ch.visited_total,
                    done_res: res_ch.done_res};
            if (expected_moves.size() == 0)
            begin
                report_mismatch("result with nothing pending", int'(got.head_cell), 0);
            end
            else
            begin
                want = expected_moves.pop_front();
                if (got.carved !== want.carved)
                    report_mismatch("carved", int'(got.carved), int'(want.carved));
                if (got.from_cell !== want.from_cell)
                    report_mismatch("from_cell", int'(got.from_cell), int'(want.from_cell));
                if (got.to_cell !== want.to_cell)
                    report_mismatch("to_cell", int'(got.to_cell), int'(want.to_cell));
                if (got.backtracked !== want.backtracked)
                    report_mismatch("backtracked", int'(got.backtracked),
                                    int'(want.backtracked));
                if (got.head_cell !== want.head_cell)
                    report_mismatch("head_cell", int'(got.head_cell), int'(want.head_cell));
                if (got.visited_total !== want.visited_total)
                    report_mismatch("visited_total", int'(got.visited_total),
                                    int'(want.visited_total));
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
            end
        end
        if (in_fire || cfg_fire || out_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        step_ch.valid       = 1'b0;
        step_ch.op          = OP_RESTART;
        step_ch.random_pick = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.start_cell   = '0;
        res_ch.ready        = 1'b0;
        start_reg           = START_CELL_RST;
        reseed_maze();

        // directed: reset start cell, pick extremes, corners and edges
        add_idle_mix(34, 61);
        add_step(OP_CARVE, 8'd0);
        add_step(OP_CARVE, 8'd255);
        add_step(OP_CARVE, 8'd1);
        add_step(OP_CARVE, 8'd2);
        add_step(OP_CARVE, 8'd3);
        add_step(OP_CARVE, 8'd127);
        add_step(OP_CARVE, 8'd128);
        add_step(OP_CARVE, 8'd85);
        add_step(OP_CARVE, 8'd170);
        add_step(OP_RESTART, 8'hA5);
        add_start_wr(10'd0);
        add_step(OP_CARVE, 8'd255);
        add_step(OP_CARVE, 8'd0);
        add_step(OP_CARVE, 8'd1);
        add_start_wr(10'd1023);
        add_step(OP_CARVE, 8'd255);
        add_step(OP_CARVE, 8'd2);
        add_start_wr(10'd31);
        add_step(OP_CARVE, 8'd170);
        add_start_wr(10'd992);
        add_step(OP_CARVE, 8'd85);

        // random, sender idling less than the receiver
        add_start_wr(10'd40);
        add_marker(ACT_HOLD_OUT);
        add_random_run(40, 3);
        add_marker(ACT_SETTLE);
        add_random_run(20, 3);
        add_start_wr(START_W'($urandom));
        add_random_run(20, 3);

        // random, receiver idling less than the sender
        add_idle_mix(61, 34);
        add_start_wr(START_W'($urandom));
        add_random_run(40, 3);
        add_marker(ACT_HOLD_OUT);
        add_random_run(40, 3);

        // no idling: carve one maze to completion, then step past the end
        add_idle_mix(0, 0);
        add_start_wr(10'd0);
        add_snake_run(CELLS - 1);
        add_random_run(10, 0);
        add_step(OP_RESTART, PICK_W'($urandom));
        add_random_run(10, 0);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (step_plan.size() != 0 || expected_moves.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/mbs_pkg.sv
hdl/mbs_if.sv
hdl/mbs_ram.sv
hdl/mbs_ctrl.sv
hdl/mbs_dp.sv
hdl/maze_backtracker_step_top.sv
tb/maze_backtracker_step_top_tb.sv
